// File: rtl/sorted_palette_indexer_macros.svh
// Assertion macros shared by the checker of the sorted palette indexer.
`ifndef SORTED_PALETTE_INDEXER_MACROS_SVH
`define SORTED_PALETTE_INDEXER_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define SPIDX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define SPIDX_ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// File: rtl/spidx_pkg.sv
// Package with the types, codes and defaults of the sorted palette indexer.
package spidx_pkg;

	localparam int MAX_WIDTH_DEF       = 256;
	localparam int MAX_HEIGHT_DEF      = 256;
	localparam int PALETTE_ENTRIES_DEF = 256;

	localparam int COLOUR_W = 24;
	localparam int DIM_W    = 9;

	localparam logic [1:0] REQ_WRITE    = 2'd0;
	localparam logic [1:0] REQ_PAL_READ = 2'd1;
	localparam logic [1:0] REQ_PIX_READ = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_OUT_RANGE  = 2'd1;
	localparam logic [1:0] ST_FULL       = 2'd2;
	localparam logic [1:0] ST_RANK_RANGE = 2'd3;

	localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

	typedef struct packed {
		logic [1:0]          req_type;
		logic signed [15:0]  x_pos;
		logic signed [15:0]  y_pos;
		logic [COLOUR_W-1:0] colour;
		logic [7:0]          entry_rank;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [COLOUR_W-1:0] read_colour;
		logic [7:0]          pixel_index;
		logic [8:0]          colour_count;
	} res_t;

	// Status of one palette cell as seen by its right neighbor and the top level.
	typedef struct packed {
		logic valid;
		logic lt;
		logic eq;
		logic bnd;
	} cell_flags_t;

endpackage

// File: rtl/spidx_ram.sv
// Generic single-port RAM with a registered read.
module spidx_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: rtl/spidx_cell.sv
// One cell of the sorted colour chain: holds one entry and shifts on insert.
module spidx_cell #(
	parameter bit RESET_VALID = 1'b0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           ins,
	input  logic [spidx_pkg::COLOUR_W-1:0] key,
	input  logic [spidx_pkg::COLOUR_W-1:0] prev_val,
	input  logic                           prev_valid,
	input  logic                           prev_lt,
	output logic [spidx_pkg::COLOUR_W-1:0] val,
	output spidx_pkg::cell_flags_t         flags
);

	logic [spidx_pkg::COLOUR_W-1:0] val_q;
	logic                           valid_q;
	logic                           lt;

	assign lt          = valid_q && (val_q < key);
	assign val         = val_q;
	assign flags.valid = valid_q;
	assign flags.lt    = lt;
	assign flags.eq    = valid_q && (val_q == key);
	// The first entry that is not below the key sits where the lower run ends.
	assign flags.bnd   = prev_lt && !lt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q   <= '0;
			valid_q <= RESET_VALID;
		end else if (ins && !lt) begin
			val_q   <= prev_lt ? key : prev_val;
			valid_q <= valid_q | prev_valid;
		end
	end

endmodule

// File: rtl/sorted_palette_indexer.sv
// Top level of the sorted palette indexer: frame store, colour chain and sequencer.
//
// Requests enter as one beat on req, taken when start is high and busy is low.
// Each request gives exactly one result beat on res, shown for one cycle with
// done high; the receiver cannot stall, so a result is never held back.
// A pixel write stores a colour in the frame and adds it to the sorted set of
// colours; a palette read returns the colour at a rank; a pixel read returns
// the colour of a pixel and its rank in the set.
// From the accepting edge, palette reads, pixel writes, pixel reads outside
// the frame and unknown requests pass the rank and done states; pixel reads
// inside the frame first pass the fetch and load states for the registered
// frame store read, before the rank search over the cell chain.
// One request is worked on at a time, so a new request is taken only once
// the last one is through.
// After reset the frame store is swept to black, one pixel a cycle, over all
// MAX_WIDTH * MAX_HEIGHT pixels (65536 at the defaults); busy stays high during
// that sweep. Configuration writes over the APB port are taken at any time,
// but must only happen while no request is in flight.
module sorted_palette_indexer #(
	parameter int MAX_WIDTH       = spidx_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT      = spidx_pkg::MAX_HEIGHT_DEF,
	parameter int PALETTE_ENTRIES = spidx_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  spidx_pkg::req_t   req,
	output logic              done,
	output spidx_pkg::res_t   res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = $clog2(PALETTE_ENTRIES);
	localparam int CW    = $clog2(PALETTE_ENTRIES + 1);
	localparam int CLW   = spidx_pkg::COLOUR_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_LOAD  = 3'd3;
	localparam logic [2:0] S_RANK  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	// Configuration registers.
	logic [spidx_pkg::DIM_W-1:0] width_q;
	logic [spidx_pkg::DIM_W-1:0] height_q;

	assign pready = 1'b1;
	assign prdata = 32'(paddr[2] ? height_q : width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= spidx_pkg::DIM_RESET;
			height_q <= spidx_pkg::DIM_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				height_q <= pwdata[spidx_pkg::DIM_W-1:0];
			end else begin
				width_q <= pwdata[spidx_pkg::DIM_W-1:0];
			end
		end
	end

	// Sequencer state and request registers.
	logic [2:0]            state_q;
	logic [AW-1:0]         clr_q;
	spidx_pkg::req_t       req_q;
	logic                  inr_q;
	logic [AW-1:0]         addr_q;
	logic [CLW-1:0]        key_q;
	logic [RW-1:0]         rank_q;
	logic                  present_q;
	logic [CLW-1:0]        pal_q;
	logic [CW-1:0]         used_q;
	logic                  done_q;
	spidx_pkg::res_t       res_q;

	logic                  accept;
	logic [15:0]           x_u;
	logic [15:0]           y_u;
	logic                  in_range;
	logic [AW-1:0]         pix_addr;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign res    = res_q;

	// A negative coordinate reads as a large unsigned value and so is out of range.
	assign x_u      = $unsigned(req.x_pos);
	assign y_u      = $unsigned(req.y_pos);
	assign in_range = (17'(x_u) < 17'(width_q)) && (17'(x_u) < 17'(MAX_WIDTH)) &&
		(17'(y_u) < 17'(height_q)) && (17'(y_u) < 17'(MAX_HEIGHT));
	assign pix_addr = AW'(32'(y_u) * 32'(MAX_WIDTH) + 32'(x_u));

	// Cell chain holding the sorted colours.
	logic [CLW-1:0]          cval  [PALETTE_ENTRIES];
	spidx_pkg::cell_flags_t  cflag [PALETTE_ENTRIES];
	logic                    cins;

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			spidx_cell #(.RESET_VALID(1'b1)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ins       (cins),
				.key       (key_q),
				.prev_val  (key_q),
				.prev_valid(1'b1),
				.prev_lt   (1'b1),
				.val       (cval[i]),
				.flags     (cflag[i])
			);
		end else begin : g_body
			spidx_cell #(.RESET_VALID(1'b0)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ins       (cins),
				.key       (key_q),
				.prev_val  (cval[i-1]),
				.prev_valid(cflag[i-1].valid),
				.prev_lt   (cflag[i-1].lt),
				.val       (cval[i]),
				.flags     (cflag[i])
			);
		end
	end

	// The boundary flag is one-hot (or absent when every cell is below the key),
	// so the rank is the OR of the flagged cell indices.
	logic [RW-1:0] rank_c;
	logic          present_c;

	always_comb begin
		rank_c    = '0;
		present_c = 1'b0;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			if (cflag[i].bnd) begin
				rank_c = rank_c | RW'(i);
			end
			present_c = present_c | cflag[i].eq;
		end
	end

	// Result of the request in its final cycle.
	logic [1:0]     st_c;
	logic [CLW-1:0] rcol_c;
	logic [7:0]     pidx_c;
	logic           grow_c;
	logic           wr_c;
	logic           full;

	assign full = (used_q == CW'(PALETTE_ENTRIES));

	always_comb begin
		st_c   = spidx_pkg::ST_OK;
		rcol_c = '0;
		pidx_c = '0;
		grow_c = 1'b0;
		wr_c   = 1'b0;
		unique case (req_q.req_type)
			spidx_pkg::REQ_WRITE: begin
				if (!inr_q) begin
					st_c = spidx_pkg::ST_OUT_RANGE;
				end else if (!present_q && full) begin
					st_c = spidx_pkg::ST_FULL;
				end else begin
					rcol_c = key_q;
					pidx_c = 8'(rank_q);
					grow_c = !present_q;
					wr_c   = 1'b1;
				end
			end
			spidx_pkg::REQ_PAL_READ: begin
				if (9'(req_q.entry_rank) >= 9'(used_q)) begin
					st_c = spidx_pkg::ST_RANK_RANGE;
				end else begin
					rcol_c = pal_q;
					pidx_c = req_q.entry_rank;
				end
			end
			spidx_pkg::REQ_PIX_READ: begin
				if (!inr_q) begin
					st_c = spidx_pkg::ST_OUT_RANGE;
				end else begin
					rcol_c = key_q;
					pidx_c = 8'(rank_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign cins = (state_q == S_DONE) && grow_c;

	// Frame store port: the reset sweep, the pixel write or the pixel read.
	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [CLW-1:0] ram_wdata;
	logic [CLW-1:0] ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = key_q;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = '0;
		end else if (state_q == S_DONE && wr_c) begin
			ram_we = 1'b1;
		end
	end

	spidx_ram #(.WIDTH(CLW), .DEPTH(DEPTH)) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			used_q  <= CW'(1);
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req.req_type == spidx_pkg::REQ_PIX_READ && in_range) begin
							state_q <= S_FETCH;
						end else begin
							state_q <= S_RANK;
						end
					end
				end
				S_FETCH: state_q <= S_LOAD;
				S_LOAD:  state_q <= S_RANK;
				S_RANK:  state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					if (grow_c) begin
						used_q <= used_q + CW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			inr_q  <= in_range;
			addr_q <= pix_addr;
			key_q  <= req.colour;
		end
		if (state_q == S_LOAD) begin
			key_q <= ram_rdata;
		end
		if (state_q == S_RANK) begin
			rank_q    <= rank_c;
			present_q <= present_c;
			pal_q     <= cval[req_q.entry_rank[RW-1:0]];
		end
		if (state_q == S_DONE) begin
			res_q.status       <= st_c;
			res_q.read_colour  <= rcol_c;
			res_q.pixel_index  <= pidx_c;
			res_q.colour_count <= 9'(used_q) + 9'(grow_c);
		end
	end

endmodule

// File: rtl/spidx_checker.sv
// Port-level checker of the sorted palette indexer and its bind statement.
`include "sorted_palette_indexer_macros.svh"

module spidx_checker #(
	parameter int PALETTE_ENTRIES = spidx_pkg::PALETTE_ENTRIES_DEF
) (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            done,
	input spidx_pkg::res_t res
);

	logic count_ok;
	logic err_ok;

	assign count_ok = (res.colour_count != 9'd0) &&
		(32'(res.colour_count) <= PALETTE_ENTRIES);
	assign err_ok = (res.status == spidx_pkg::ST_OK) ||
		(res.read_colour == '0 && res.pixel_index == '0);

	// An accepted request beat raises busy.
	`SPIDX_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

	// Results of two requests cannot land in adjacent cycles.
	`SPIDX_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held for two cycles")

	// The palette always holds black and never more than its capacity.
	`SPIDX_ASSERT(a_count_range, !done || count_ok, "colour count out of range")

	// A refused or failed request reports no colour and no index.
	`SPIDX_ASSERT(a_err_zero, !done || err_ok, "error result carries data")

endmodule

bind sorted_palette_indexer spidx_checker #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_spidx_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.res   (res)
);

// File: verif/sorted_palette_indexer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the sorted palette indexer: stimulus, frame and palette predictor, checks.
module sorted_palette_indexer_tb;

	localparam int FRAME_W = spidx_pkg::MAX_WIDTH_DEF;
	localparam int FRAME_H = spidx_pkg::MAX_HEIGHT_DEF;
	localparam int PAL_MAX = spidx_pkg::PALETTE_ENTRIES_DEF;

	// The package names only the three real request kinds; kind 3 is undefined.
	localparam logic [1:0] REQ_NONE = 2'd3;

	// Register addresses on the APB port: image_width, then image_height.
	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	// The reset sweep of the frame store keeps busy high while it clears all
	// FRAME_W * FRAME_H pixels, so the watchdog must outlast it by a wide margin.
	localparam int WATCHDOG_LIMIT = 4 * FRAME_W * FRAME_H;
	// Cycles allowed after the last result before the block counts as idle.
	localparam int SETTLE_CYCLES = 8;
	localparam int COLOUR_POOL_N = 8;

	logic            clk;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	spidx_pkg::req_t req = '0;
	logic            done;
	spidx_pkg::res_t res;
	logic            psel = 1'b0;
	logic            penable = 1'b0;
	logic            pwrite = 1'b0;
	logic [2:0]      paddr = '0;
	logic [31:0]     pwdata = '0;
	logic [31:0]     prdata;
	logic            pready;

	sorted_palette_indexer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Requests waiting to be offered, and the results predicted for the requests
	// that the block has already taken, oldest first.
	spidx_pkg::req_t request_backlog[$];
	spidx_pkg::res_t awaited_results[$];

	// Shadow of the block: the frame, the sorted set of distinct colours and the
	// two dimension registers. It only moves when a request beat is accepted or
	// a register write is made, so it always mirrors what the block must hold.
	logic [23:0] frame_colour [FRAME_W * FRAME_H];
	logic [23:0] palette_set [PAL_MAX];
	int unsigned palette_size;
	logic [8:0]  width_reg;
	logic [8:0]  height_reg;

	int              sender_idle_pct;
	int              mismatches;
	int              quiet_cycles;
	logic [23:0]     colour_pool [COLOUR_POOL_N];
	int unsigned     fresh_id;
	spidx_pkg::res_t got_want;

	// Position of the first colour in the set that is not below c. When c is in
	// the set this is its palette index, otherwise the place it would go.
	function automatic int unsigned rank_of(logic [23:0] c);
		int unsigned lo;
		lo = 0;
		while (lo < palette_size && palette_set[lo] < c)
			lo++;
		return lo;
	endfunction

	// Coordinates are taken as raw 16-bit values, so a negative one has bit 15
	// set and falls above every bound. The register and the frame size both cap
	// the range, and a register value of zero leaves no pixel at all.
	function automatic bit pixel_slot(logic [15:0] xb, logic [15:0] yb,
			output int unsigned slot);
		int unsigned xu;
		int unsigned yu;
		xu = xb;
		yu = yb;
		slot = 0;
		if (xu >= width_reg || xu >= FRAME_W)
			return 1'b0;
		if (yu >= height_reg || yu >= FRAME_H)
			return 1'b0;
		slot = yu * FRAME_W + xu;
		return 1'b1;
	endfunction

	// Applies one request to the shadow state and returns the result beat the
	// block must give for it. Fields that a failing or unknown request leaves
	// unused stay zero; the colour count is always the count after the request.
	function automatic spidx_pkg::res_t resolve_request(spidx_pkg::req_t r);
		spidx_pkg::res_t o;
		int unsigned     slot;
		int unsigned     pos;
		bit              known;
		o = '0;
		case (r.req_type)
		spidx_pkg::REQ_WRITE: begin
			if (!pixel_slot(r.x_pos, r.y_pos, slot)) begin
				o.status = spidx_pkg::ST_OUT_RANGE;
			end else begin
				pos = rank_of(r.colour);
				known = pos < palette_size && palette_set[pos] == r.colour;
				if (!known && palette_size >= PAL_MAX) begin
					// A new colour with the set full is refused whole: the
					// pixel keeps its old colour too.
					o.status = spidx_pkg::ST_FULL;
				end else begin
					if (!known) begin
						for (int i = palette_size; i > int'(pos); i--)
							palette_set[i] = palette_set[i - 1];
						palette_set[pos] = r.colour;
						palette_size++;
					end
					frame_colour[slot] = r.colour;
					o.read_colour = r.colour;
					o.pixel_index = 8'(pos);
				end
			end
		end
		spidx_pkg::REQ_PAL_READ: begin
			if (r.entry_rank >= palette_size) begin
				o.status = spidx_pkg::ST_RANK_RANGE;
			end else begin
				o.read_colour = palette_set[r.entry_rank];
				o.pixel_index = r.entry_rank;
			end
		end
		spidx_pkg::REQ_PIX_READ: begin
			if (!pixel_slot(r.x_pos, r.y_pos, slot)) begin
				o.status = spidx_pkg::ST_OUT_RANGE;
			end else begin
				o.read_colour = frame_colour[slot];
				o.pixel_index = 8'(rank_of(frame_colour[slot]));
			end
		end
		default: begin
			// The unknown kind changes nothing and reports ok.
		end
		endcase
		o.colour_count = 9'(palette_size);
		return o;
	endfunction

	// Request driver. start stays up with the same beat until the block takes
	// it; between beats the sender may idle, and while start is low the request
	// lines carry noise that the block must ignore.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy) begin
				awaited_results.push_back(resolve_request(req));
				request_backlog.pop_front();
			end
			if (!start || !busy) begin
				if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					start <= 1'b1;
					req <= request_backlog[0];
				end else begin
					start <= 1'b0;
					req <= {$urandom, $urandom, 2'($urandom)};
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Result monitor. The receiver cannot stall, so every cycle with done high
	// is one result beat, matched in order against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (awaited_results.size() == 0) begin
				$error("result beat with no request outstanding");
				mismatches++;
			end else begin
				got_want = awaited_results.pop_front();
				check_field("status", 32'(got_want.status), 32'(res.status));
				check_field("read_colour", 32'(got_want.read_colour),
					32'(res.read_colour));
				check_field("pixel_index", 32'(got_want.pixel_index),
					32'(res.pixel_index));
				check_field("colour_count", 32'(got_want.colour_count),
					32'(res.colour_count));
			end
		end
	end

	// Watchdog: ends the run when neither a request nor a result beat has moved
	// for far longer than the slowest correct run would take.
	always @(posedge clk) begin
		if ((start && !busy) || done === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic queue_request(logic [1:0] kind, logic [15:0] xb, logic [15:0] yb,
			logic [23:0] c, logic [7:0] rank);
		spidx_pkg::req_t r;
		r.req_type = kind;
		r.x_pos = xb;
		r.y_pos = yb;
		r.colour = c;
		r.entry_rank = rank;
		request_backlog.push_back(r);
	endtask

	// A setup cycle, then an access cycle held until pready; the shadow register
	// follows at once since writes are only made while the block is idle.
	task automatic write_reg(logic [2:0] addr, logic [8:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {23'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_WIDTH)
			width_reg = value;
		else
			height_reg = value;
	endtask

	// The sender holds back until every request has been offered and answered,
	// then lets the block come to rest.
	task automatic drain();
		do @(posedge clk); while (request_backlog.size() != 0 || awaited_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly in-range coordinates, with the bounds, the sign extremes and raw
	// noise mixed in. span is the number of usable columns or rows.
	function automatic logic [15:0] random_coord(int unsigned span);
		case ($urandom_range(9))
		0: return 16'($urandom);
		1: begin
			case ($urandom_range(3))
			0: return 16'(span);
			1: return 16'hffff;
			2: return 16'h7fff;
			default: return 16'h8000;
			endcase
		end
		default: return span == 0 ? 16'($urandom) : 16'($urandom_range(span - 1));
		endcase
	endfunction

	// Colours already in the set, a small pool shared by the phase, or noise;
	// repeats are what make pixel reads and sorted lookups interesting.
	function automatic logic [23:0] random_colour();
		case ($urandom_range(9))
		0, 1, 2: return 24'($urandom);
		3, 4, 5: return palette_set[$urandom_range(palette_size - 1)];
		default: return colour_pool[$urandom_range(COLOUR_POOL_N - 1)];
		endcase
	endfunction

	task automatic queue_random_request();
		int unsigned pick;
		int unsigned w_span;
		int unsigned h_span;
		int unsigned rank_top;
		logic [1:0]  kind;
		logic [7:0]  rank;
		pick = $urandom_range(99);
		w_span = width_reg < FRAME_W ? width_reg : FRAME_W;
		h_span = height_reg < FRAME_H ? height_reg : FRAME_H;
		rank_top = palette_size + 1 < 255 ? palette_size + 1 : 255;
		if (pick < 40)
			kind = spidx_pkg::REQ_WRITE;
		else if (pick < 65)
			kind = spidx_pkg::REQ_PAL_READ;
		else if (pick < 93)
			kind = spidx_pkg::REQ_PIX_READ;
		else
			kind = REQ_NONE;
		if ($urandom_range(4) == 0)
			rank = 8'($urandom);
		else
			rank = 8'($urandom_range(rank_top));
		queue_request(kind, random_coord(w_span), random_coord(h_span), random_colour(), rank);
	endtask

	// One phase: wait for the block to go idle, set the frame size, choose how
	// often the sender idles, then queue the phase's requests. With fill set,
	// five requests in six write a colour that was never used before, so the
	// set runs full and the later new colours are refused.
	task automatic run_phase(logic [8:0] w, logic [8:0] h, int idle_pct, int count, bit fill);
		drain();
		write_reg(ADDR_WIDTH, w);
		write_reg(ADDR_HEIGHT, h);
		sender_idle_pct = idle_pct;
		colour_pool[0] = 24'h000000;
		colour_pool[1] = 24'hffffff;
		for (int i = 2; i < COLOUR_POOL_N; i++)
			colour_pool[i] = 24'($urandom);
		for (int k = 0; k < count; k++) begin
			if (fill && k % 6 != 5) begin
				queue_request(spidx_pkg::REQ_WRITE, 16'($urandom_range(FRAME_W - 1)),
					16'($urandom_range(FRAME_H - 1)), {fresh_id[8:0], 15'($urandom)},
					8'($urandom));
				fresh_id++;
			end else begin
				queue_random_request();
			end
		end
	endtask

	initial begin
		sender_idle_pct = 0;
		mismatches = 0;
		quiet_cycles = 0;
		fresh_id = 0;
		width_reg = spidx_pkg::DIM_RESET;
		height_reg = spidx_pkg::DIM_RESET;
		palette_size = 1;
		foreach (frame_colour[i])
			frame_colour[i] = '0;
		foreach (palette_set[i])
			palette_set[i] = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening at the reset frame size. These sit in the backlog
		// through the clearing sweep and go in as soon as busy drops.
		// Fresh set: only black, so rank 0 holds and every higher rank fails.
		queue_request(spidx_pkg::REQ_PAL_READ, 16'($urandom), 16'($urandom),
			24'($urandom), 8'd0);
		queue_request(spidx_pkg::REQ_PAL_READ, 16'($urandom), 16'($urandom),
			24'($urandom), 8'd1);
		queue_request(spidx_pkg::REQ_PAL_READ, 16'($urandom), 16'($urandom),
			24'($urandom), 8'd255);
		// Corners read back black; one past the edge, negative and the
		// extremes of the signed range are out of range.
		queue_request(spidx_pkg::REQ_PIX_READ, 16'd0, 16'd0, 24'($urandom), 8'($urandom));
		queue_request(spidx_pkg::REQ_PIX_READ, 16'd255, 16'd255, 24'($urandom), 8'($urandom));
		queue_request(spidx_pkg::REQ_PIX_READ, 16'd256, 16'd0, 24'($urandom), 8'($urandom));
		queue_request(spidx_pkg::REQ_PIX_READ, 16'd0, 16'hffff, 24'($urandom), 8'($urandom));
		queue_request(spidx_pkg::REQ_PIX_READ, 16'h8000, 16'h7fff, 24'($urandom), 8'($urandom));
		// Writes of the largest colour and the smallest one above black, a write
		// of black which is already held, and writes that miss the frame.
		queue_request(spidx_pkg::REQ_WRITE, 16'd0, 16'd0, 24'hffffff, 8'($urandom));
		queue_request(spidx_pkg::REQ_WRITE, 16'd255, 16'd255, 24'h000001, 8'($urandom));
		queue_request(spidx_pkg::REQ_WRITE, 16'd1, 16'd0, 24'h000000, 8'($urandom));
		queue_request(spidx_pkg::REQ_WRITE, 16'hffff, 16'd5, 24'h123456, 8'($urandom));
		queue_request(spidx_pkg::REQ_WRITE, 16'd3, 16'd256, 24'h654321, 8'($urandom));
		queue_request(spidx_pkg::REQ_WRITE, 16'h7fff, 16'd0, 24'habcdef, 8'($urandom));
		// Read back what stuck, by pixel and by rank, and just past the count.
		queue_request(spidx_pkg::REQ_PIX_READ, 16'd0, 16'd0, 24'($urandom), 8'($urandom));
		queue_request(spidx_pkg::REQ_PIX_READ, 16'd255, 16'd255, 24'($urandom), 8'($urandom));
		queue_request(spidx_pkg::REQ_PAL_READ, 16'($urandom), 16'($urandom),
			24'($urandom), 8'd2);
		queue_request(spidx_pkg::REQ_PAL_READ, 16'($urandom), 16'($urandom),
			24'($urandom), 8'd3);
		// The unknown kind, with random and with all-ones fields.
		queue_request(REQ_NONE, 16'($urandom), 16'($urandom), 24'($urandom), 8'($urandom));
		// A colour landing in the middle of the set shifts the ranks above it.
		queue_request(spidx_pkg::REQ_WRITE, 16'd10, 16'd20, 24'h800000, 8'($urandom));
		queue_request(spidx_pkg::REQ_PAL_READ, 16'($urandom), 16'($urandom),
			24'($urandom), 8'd2);
		queue_request(spidx_pkg::REQ_PAL_READ, 16'($urandom), 16'($urandom),
			24'($urandom), 8'd3);
		queue_request(spidx_pkg::REQ_PIX_READ, 16'd0, 16'd0, 24'($urandom), 8'($urandom));
		queue_request(REQ_NONE, 16'hffff, 16'hffff, 24'hffffff, 8'hff);

		// Random phases over a range of frame sizes, down to a single pixel
		// and to no pixels at all, and above the frame size where the frame
		// itself caps the range. Each starts only once the block is idle.
		run_phase(9'd1, 9'd1, 0, 40, 1'b0);
		run_phase(9'd7, 9'd3, 45, 50, 1'b0);
		run_phase(9'd0, 9'd256, 21, 20, 1'b0);
		run_phase(9'd511, 9'd16, 0, 40, 1'b0);
		run_phase(9'd256, 9'd256, 21, 312, 1'b1);
		run_phase(9'd200, 9'd5, 45, 60, 1'b0);

		drain();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sorted_palette_indexer.f
+incdir+rtl
rtl/spidx_pkg.sv
rtl/spidx_ram.sv
rtl/spidx_cell.sv
rtl/sorted_palette_indexer.sv
rtl/spidx_checker.sv
verif/sorted_palette_indexer_tb.sv
